[src/zero_tracking_modular_product_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for zero_tracking_modular_product
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ZERO_TRACKING_MODULAR_PRODUCT_MACROS_SVH
`define ZERO_TRACKING_MODULAR_PRODUCT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define ZTMP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is asserted
`define ZTMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ZTMP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/ztmp_pkg.sv]
// ---------------------------------------------------------------------------
// ztmp_pkg
// Widths, codes and controller/datapath interface types shared by the
// zero-tracking modular product block.
// ---------------------------------------------------------------------------
package ztmp_pkg;

  localparam int MOD_BITS   = 31;
  localparam int CNT_BITS   = 32;
  localparam int OP_BITS    = 64;
  localparam int STEP_W     = 7;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(998244353);

  // step counts of the shared reduce/multiply unit
  localparam logic [STEP_W-1:0] STEPS_OP  = STEP_W'(OP_BITS);
  localparam logic [STEP_W-1:0] STEPS_MOD = STEP_W'(MOD_BITS);

  // request kinds
  localparam logic [1:0] REQ_MUL  = 2'd0;
  localparam logic [1:0] REQ_DIV  = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  // configuration register index (paddr bit 2)
  localparam logic REG_MODULUS = 1'b0;

  // multiply operand selects: a x b
  localparam logic [1:0] MS_X_R = 2'd0;
  localparam logic [1:0] MS_X_P = 2'd1;
  localparam logic [1:0] MS_P_B = 2'd2;
  localparam logic [1:0] MS_B_B = 2'd3;

  // destinations for the unit's result
  localparam logic [2:0] SV_NONE = 3'd0;
  localparam logic [2:0] SV_R    = 3'd1;
  localparam logic [2:0] SV_X    = 3'd2;
  localparam logic [2:0] SV_P    = 3'd3;
  localparam logic [2:0] SV_B    = 3'd4;

  typedef struct packed {
    logic       ld_op;      // capture input item, start operand reduction
    logic       ld_x;       // start reduction of the kept nonzero part
    logic       start_mul;  // start a modular multiply
    logic [1:0] mul_sel;
    logic       step;       // advance the shared unit one bit
    logic [2:0] save_dst;
    logic       pow_init;   // set up the Fermat power
    logic       exp_shift;  // drop the exponent's low bit
    logic       commit;     // update state and load the output register
  } ztmp_cmd_t;

  typedef struct packed {
    logic       op_zero;
    logic [1:0] kind;
    logic       exp_zero;
    logic       exp_lsb;
    logic       exp_last;
    logic       out_free;
  } ztmp_stat_t;

endpackage

[src/ztmp_dpath.sv]
// ---------------------------------------------------------------------------
// ztmp_dpath
// Datapath: bit-serial modular reduce/multiply unit, operand and power
// registers, kept state and the output register.
// ---------------------------------------------------------------------------
module ztmp_dpath
  import ztmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MOD_BITS-1:0] cfg_mod,
  input  logic [OP_BITS-1:0]  in_op,
  input  logic [1:0]          in_kind,
  input  ztmp_cmd_t           cmd,
  output ztmp_stat_t          stat,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [MOD_BITS-1:0] out_product,
  output logic [MOD_BITS-1:0] out_nonzero,
  output logic [CNT_BITS-1:0] out_count
);

  localparam int V_W = MOD_BITS + 2;

  logic [MOD_BITS-1:0] m;
  logic [OP_BITS-1:0]  shift_r, shift_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] mula_r, mula_nxt;
  logic                neg_r, neg_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [MOD_BITS-1:0] r_r, r_nxt;
  logic [MOD_BITS-1:0] x_r, x_nxt;
  logic [MOD_BITS-1:0] pacc_r, pacc_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [MOD_BITS-1:0] exp_r, exp_nxt;
  logic [MOD_BITS-1:0] kept_r, kept_nxt;
  logic [CNT_BITS-1:0] zcnt_r, zcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MOD_BITS-1:0] out_prod_r, out_prod_nxt;
  logic [MOD_BITS-1:0] out_nz_r, out_nz_nxt;
  logic [CNT_BITS-1:0] out_cnt_r, out_cnt_nxt;

  logic [OP_BITS-1:0]  op_mag;
  logic [MOD_BITS-1:0] addend, step_val;
  logic [V_W-1:0]      v, v_m1, v_m2, sub1, sub2;
  logic [MOD_BITS-1:0] mul_a, mul_b;
  logic [MOD_BITS-1:0] new_kept;
  logic [CNT_BITS-1:0] new_cnt;
  logic                op_zero;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {1'b0, {(CNT_BITS-1){1'b1}}};
  localparam logic [CNT_BITS-1:0] CNT_MIN = {1'b1, {(CNT_BITS-1){1'b0}}};

  // moduli below two act as two
  assign m = (cfg_mod < MOD_BITS'(2)) ? MOD_BITS'(2) : cfg_mod;

  assign op_mag  = in_op[OP_BITS-1] ? (~in_op + OP_BITS'(1)) : in_op;
  assign op_zero = (r_r == '0);

  // one bit of (2*acc + bit*a) mod m; the sum stays below 3m
  assign addend = shift_r[OP_BITS-1] ? mula_r : '0;
  assign v      = {1'b0, acc_r, 1'b0} + {2'b00, addend};
  assign v_m1   = {2'b00, m};
  assign v_m2   = {1'b0, m, 1'b0};
  assign sub1   = v - v_m1;
  assign sub2   = v - v_m2;
  always_comb begin
    if (v >= v_m2) begin
      step_val = sub2[MOD_BITS-1:0];
    end else if (v >= v_m1) begin
      step_val = sub1[MOD_BITS-1:0];
    end else begin
      step_val = v[MOD_BITS-1:0];
    end
  end

  // select multiply operands
  always_comb begin
    case (cmd.mul_sel)
      MS_X_R: begin
        mul_a = x_r;
        mul_b = r_r;
      end
      MS_X_P: begin
        mul_a = x_r;
        mul_b = pacc_r;
      end
      MS_P_B: begin
        mul_a = pacc_r;
        mul_b = base_r;
      end
      MS_B_B: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = r_r;
      end
    endcase
  end

  // state update for the finished item
  always_comb begin
    new_kept = x_r;
    new_cnt  = zcnt_r;
    case (kind_r)
      REQ_LOAD: begin
        new_kept = op_zero ? MOD_BITS'(1) : r_r;
        new_cnt  = op_zero ? CNT_BITS'(1) : '0;
      end
      REQ_MUL: begin
        if (op_zero && (zcnt_r != CNT_MAX)) begin
          new_cnt = zcnt_r + CNT_BITS'(1);
        end
      end
      REQ_DIV: begin
        if (op_zero && (zcnt_r != CNT_MIN)) begin
          new_cnt = zcnt_r - CNT_BITS'(1);
        end
      end
      default: begin
        new_kept = x_r;
      end
    endcase
  end

  // next-state logic for the datapath registers
  always_comb begin
    shift_nxt     = shift_r;
    acc_nxt       = acc_r;
    mula_nxt      = mula_r;
    neg_nxt       = neg_r;
    kind_nxt      = kind_r;
    r_nxt         = r_r;
    x_nxt         = x_r;
    pacc_nxt      = pacc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    kept_nxt      = kept_r;
    zcnt_nxt      = zcnt_r;
    out_valid_nxt = out_valid_r;
    out_prod_nxt  = out_prod_r;
    out_nz_nxt    = out_nz_r;
    out_cnt_nxt   = out_cnt_r;

    if (cmd.ld_op) begin
      shift_nxt = op_mag;
      acc_nxt   = '0;
      mula_nxt  = MOD_BITS'(1);
      neg_nxt   = in_op[OP_BITS-1];
      kind_nxt  = in_kind;
    end
    if (cmd.ld_x) begin
      shift_nxt = {kept_r, {(OP_BITS-MOD_BITS){1'b0}}};
      acc_nxt   = '0;
      mula_nxt  = MOD_BITS'(1);
    end
    if (cmd.start_mul) begin
      shift_nxt = {mul_b, {(OP_BITS-MOD_BITS){1'b0}}};
      acc_nxt   = '0;
      mula_nxt  = mul_a;
    end
    if (cmd.step) begin
      shift_nxt = {shift_r[OP_BITS-2:0], 1'b0};
      acc_nxt   = step_val;
    end

    case (cmd.save_dst)
      SV_R:    r_nxt    = (neg_r && (acc_r != '0)) ? (m - acc_r) : acc_r;
      SV_X:    x_nxt    = acc_r;
      SV_P:    pacc_nxt = acc_r;
      SV_B:    base_nxt = acc_r;
      default: r_nxt    = r_r;
    endcase

    if (cmd.pow_init) begin
      pacc_nxt = MOD_BITS'(1);
      base_nxt = r_r;
      exp_nxt  = m - MOD_BITS'(2);
    end
    if (cmd.exp_shift) begin
      exp_nxt = {1'b0, exp_r[MOD_BITS-1:1]};
    end

    // drain the output register, then refill on commit
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      kept_nxt      = new_kept;
      zcnt_nxt      = new_cnt;
      out_valid_nxt = 1'b1;
      out_prod_nxt  = ($signed(new_cnt) > 0) ? '0 : new_kept;
      out_nz_nxt    = new_kept;
      out_cnt_nxt   = new_cnt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r      <= MOD_BITS'(1);
      zcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kept_r      <= kept_nxt;
      zcnt_r      <= zcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    acc_r      <= acc_nxt;
    mula_r     <= mula_nxt;
    neg_r      <= neg_nxt;
    kind_r     <= kind_nxt;
    r_r        <= r_nxt;
    x_r        <= x_nxt;
    pacc_r     <= pacc_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    out_prod_r <= out_prod_nxt;
    out_nz_r   <= out_nz_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign stat.op_zero  = op_zero;
  assign stat.kind     = kind_r;
  assign stat.exp_zero = (exp_r == '0);
  assign stat.exp_lsb  = exp_r[0];
  assign stat.exp_last = (exp_r[MOD_BITS-1:1] == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid  = out_valid_r;
  assign out_product = out_prod_r;
  assign out_nonzero = out_nz_r;
  assign out_count   = out_cnt_r;

endmodule

[src/ztmp_ctrl.sv]
// ---------------------------------------------------------------------------
// ztmp_ctrl
// Controller: sequences operand reduction, state reduction, the optional
// multiply or Fermat power, and the commit of each item.
// ---------------------------------------------------------------------------
module ztmp_ctrl
  import ztmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ztmp_stat_t stat,
  output ztmp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROP    = 4'd1;
  localparam logic [3:0] S_SROP   = 4'd2;
  localparam logic [3:0] S_RX     = 4'd3;
  localparam logic [3:0] S_SRX    = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_MF     = 4'd6;
  localparam logic [3:0] S_SMF    = 4'd7;
  localparam logic [3:0] S_PCHK   = 4'd8;
  localparam logic [3:0] S_PM     = 4'd9;
  localparam logic [3:0] S_SPM    = 4'd10;
  localparam logic [3:0] S_PS     = 4'd11;
  localparam logic [3:0] S_SPS    = 4'd12;
  localparam logic [3:0] S_COMMIT = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              last_step;

  assign last_step = (cnt_r == STEP_W'(1));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_op = 1'b1;
          cnt_nxt   = STEPS_OP;
          state_nxt = S_ROP;
        end
      end
      // reduce the operand magnitude
      S_ROP: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = S_SROP;
        end
      end
      S_SROP: begin
        cmd.save_dst = SV_R;
        cmd.ld_x     = 1'b1;
        cnt_nxt      = STEPS_MOD;
        state_nxt    = S_RX;
      end
      // reduce the kept nonzero part under the current modulus
      S_RX: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = S_SRX;
        end
      end
      S_SRX: begin
        cmd.save_dst = SV_X;
        state_nxt    = S_DEC;
      end
      // pick the work for this request
      S_DEC: begin
        if ((stat.kind == REQ_MUL) && !stat.op_zero) begin
          cmd.start_mul = 1'b1;
          cmd.mul_sel   = MS_X_R;
          cnt_nxt       = STEPS_MOD;
          state_nxt     = S_MF;
        end else if ((stat.kind == REQ_DIV) && !stat.op_zero) begin
          cmd.pow_init = 1'b1;
          state_nxt    = S_PCHK;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      // final multiply into the nonzero part
      S_MF: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = S_SMF;
        end
      end
      S_SMF: begin
        cmd.save_dst = SV_X;
        state_nxt    = S_COMMIT;
      end
      // square-and-multiply, low exponent bit first
      S_PCHK: begin
        cmd.start_mul = 1'b1;
        cnt_nxt       = STEPS_MOD;
        if (stat.exp_zero) begin
          cmd.mul_sel = MS_X_P;
          state_nxt   = S_MF;
        end else if (stat.exp_lsb) begin
          cmd.mul_sel = MS_P_B;
          state_nxt   = S_PM;
        end else begin
          cmd.mul_sel = MS_B_B;
          state_nxt   = S_PS;
        end
      end
      S_PM: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = S_SPM;
        end
      end
      S_SPM: begin
        cmd.save_dst = SV_P;
        if (stat.exp_last) begin
          cmd.exp_shift = 1'b1;
          state_nxt     = S_PCHK;
        end else begin
          cmd.start_mul = 1'b1;
          cmd.mul_sel   = MS_B_B;
          cnt_nxt       = STEPS_MOD;
          state_nxt     = S_PS;
        end
      end
      S_PS: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = S_SPS;
        end
      end
      S_SPS: begin
        cmd.save_dst  = SV_B;
        cmd.exp_shift = 1'b1;
        state_nxt     = S_PCHK;
      end
      // hold until the output register can take the result
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/zero_tracking_modular_product.sv]
// ---------------------------------------------------------------------------
// zero_tracking_modular_product
// Running product modulo a prime, kept as a nonzero part and a saturating
// count of zero factors; load, multiply or divide by a signed operand.
//
//   channel  | dir | handshake             | payload
//   in_      | in  | in_tvalid/in_tready   | tuser: req_type; tdata: operand
//   out_     | out | out_tvalid/out_tready | tdata: product, nonzero, count
//   cfg_     | in  | APB psel/penable      | reg 0 at 0x0: prime_modulus
//
// One item at a time on a shared bit-serial modular unit (one bit a cycle).
// Load, zero factors and request code 3 take 64 operand reduction steps
// and 31 state reduction steps. A nonzero multiply adds one modular
// multiply; a nonzero divide adds a Fermat power (one multiply per set bit
// of modulus-2, one square per significant bit but the top) and a final multiply.
// Synchronous active-low reset; the output register lets a new item in
// while a result waits, and a stalled output holds the item at commit.
// ---------------------------------------------------------------------------
module zero_tracking_modular_product
  import ztmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] operand_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [30:0] product_value, [61:31] nonzero_part,
                                  // [93:62] zero_factor_count, [95:94] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [MOD_BITS-1:0] mod_r, mod_nxt;
  logic                cfg_wr;
  ztmp_cmd_t           cmd;
  ztmp_stat_t          stat;
  logic [MOD_BITS-1:0] out_product, out_nonzero;
  logic [CNT_BITS-1:0] out_count;

  // modulus register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mod_nxt    = (cfg_wr && (cfg_paddr[2] == REG_MODULUS)) ?
                      cfg_pwdata[MOD_BITS-1:0] : mod_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODULUS) ?
                      {{(32-MOD_BITS){1'b0}}, mod_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else begin
      mod_r <= mod_nxt;
    end
  end

  ztmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ztmp_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_mod     (mod_r),
    .in_op       (in_tdata),
    .in_kind     (in_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_product (out_product),
    .out_nonzero (out_nonzero),
    .out_count   (out_count)
  );

  // pack result fields, low field first
  assign out_tdata = {2'b00, out_count, out_nonzero, out_product};

endmodule

[src/ztmp_check.sv]
// ---------------------------------------------------------------------------
// ztmp_check
// Port-level checker for the zero-tracking modular product, bound to the
// top level.
// ---------------------------------------------------------------------------
`include "zero_tracking_modular_product_macros.svh"

module ztmp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // hold a stalled result
  `ZTMP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // report zero while zero factors remain
  `ZTMP_ASSERT_NOW(a_zero_product, clk, rst_n, out_tvalid && ($signed(out_tdata[93:62]) > 0), out_tdata[30:0] == '0, "product not zero with positive zero count")

  // report the nonzero part otherwise
  `ZTMP_ASSERT_NOW(a_plain_product, clk, rst_n, out_tvalid && ($signed(out_tdata[93:62]) <= 0), out_tdata[30:0] == out_tdata[61:31], "product differs from nonzero part")

  // one item at a time
  `ZTMP_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "second item taken while busy")

  // drop the result register on reset
  `ZTMP_ASSERT_ALWAYS(a_reset_out, clk, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind zero_tracking_modular_product ztmp_check u_check (.*);

[dv/ztmp_product_checker.sv]
// ---------------------------------------------------------------------------
// ztmp_product_checker
// Watches the input, result and configuration channels of the zero-tracking
// modular product block, tracks the running product and zero count on its
// own, and compares every result item field by field with its prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ztmp_product_checker
  import ztmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic [MOD_BITS-1:0]        product;
    logic [MOD_BITS-1:0]        nonzero;
    logic signed [CNT_BITS-1:0] zeros;
  } product_t;

  localparam logic signed [CNT_BITS-1:0] ZEROS_MAX = {1'b0, {(CNT_BITS-1){1'b1}}};
  localparam logic signed [CNT_BITS-1:0] ZEROS_MIN = {1'b1, {(CNT_BITS-1){1'b0}}};

  logic [MOD_BITS-1:0]        modulus;
  logic [MOD_BITS-1:0]        kept_nonzero;
  logic signed [CNT_BITS-1:0] kept_zeros;
  product_t                   expected_products[$];
  int                         fail_count;

  // a * b mod m on a double-width product
  function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return 64'(wide % {64'd0, m});
  endfunction

  // r^(m-2) mod m by square-and-multiply
  function automatic logic [63:0] fermat_inverse(input logic [63:0] r, input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] base;
    logic [63:0] e;
    acc  = 64'd1 % m;
    base = r;
    e    = m - 64'd2;
    while (e != 64'd0) begin
      if (e[0]) acc = mod_mul(acc, base, m);
      base = mod_mul(base, base, m);
      e    = e >> 1;
    end
    return acc;
  endfunction

  // apply one request to the kept state and return the result it reports
  function automatic product_t advance_product(input logic [1:0] kind,
                                               input logic [63:0] operand);
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] x;
    logic        zero;
    product_t    res;
    m   = (modulus < 2) ? 64'd2 : 64'(modulus);
    mag = operand[63] ? -operand : operand;
    r   = mag % m;
    if (operand[63] && r != 64'd0) r = m - r;
    zero = (r == 64'd0);
    // a modulus change reduces the kept part before use
    x = 64'(kept_nonzero) % m;
    case (kind)
      REQ_LOAD: begin
        x          = zero ? 64'd1 : r;
        kept_zeros = zero ? CNT_BITS'(1) : '0;
      end
      REQ_MUL: begin
        if (zero) begin
          if (kept_zeros != ZEROS_MAX) kept_zeros = kept_zeros + 1;
        end else begin
          x = mod_mul(x, r, m);
        end
      end
      REQ_DIV: begin
        if (zero) begin
          if (kept_zeros != ZEROS_MIN) kept_zeros = kept_zeros - 1;
        end else begin
          x = mod_mul(x, fermat_inverse(r, m), m);
        end
      end
      default: ;
    endcase
    kept_nonzero = x[MOD_BITS-1:0];
    res.product  = (kept_zeros > 0) ? '0 : x[MOD_BITS-1:0];
    res.nonzero  = x[MOD_BITS-1:0];
    res.zeros    = kept_zeros;
    return res;
  endfunction

  // track configuration, predict accepted items, compare accepted results
  always @(posedge clk) begin
    product_t exp_res;
    product_t got_res;
    if (!rst_n) begin
      modulus      = MOD_RESET;
      kept_nonzero = MOD_BITS'(1);
      kept_zeros   = '0;
      expected_products.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_MODULUS) begin
        if (cfg_pwrite) begin
          modulus = cfg_pwdata[MOD_BITS-1:0];
        end else if (cfg_prdata != 32'(modulus)) begin
          fail_count++;
          if (fail_count <= 10)
            $display("modulus read mismatch: expected %0d, got %0d", modulus, cfg_prdata);
        end
      end

      if (out_tvalid && out_tready) begin
        got_res.product = out_tdata[MOD_BITS-1:0];
        got_res.nonzero = out_tdata[2*MOD_BITS-1:MOD_BITS];
        got_res.zeros   = out_tdata[2*MOD_BITS+CNT_BITS-1:2*MOD_BITS];
        if (expected_products.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result item with none expected: %h", out_tdata);
        end else begin
          exp_res = expected_products.pop_front();
          if (got_res != exp_res) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected product %0d nonzero %0d zeros %0d, got %s",
                       exp_res.product, exp_res.nonzero, exp_res.zeros,
                       $sformatf("product %0d nonzero %0d zeros %0d",
                                 got_res.product, got_res.nonzero, got_res.zeros));
          end
        end
      end

      if (in_tvalid && in_tready)
        expected_products.push_back(advance_product(in_tuser, in_tdata));
    end
    pending  <= expected_products.size();
    failures <= fail_count;
  end

endmodule

[dv/zero_tracking_modular_product_tb.sv]
// ---------------------------------------------------------------------------
// zero_tracking_modular_product_tb
// Drives load, multiply, divide and unused-code items through the
// zero-tracking modular product block under several moduli and idle
// patterns; a checker beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module zero_tracking_modular_product_tb;
  import ztmp_pkg::*;

  localparam logic [1:0]  REQ_UNUSED       = 2'd3;
  localparam logic [2:0]  CFG_ADDR_MODULUS = 3'd0;
  localparam logic [63:0] P0               = 64'(MOD_RESET);
  localparam logic [63:0] OP_MAX           = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] OP_MIN           = 64'h8000_0000_0000_0000;
  localparam int          CYCLE_LIMIT      = 20_000_000;
  localparam int          DRAIN_CYCLES     = 2500;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [63:0] operand_value
  logic [1:0]  in_tuser    = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;          // [30:0] product, [61:31] nonzero, [93:62] zeros
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int failures;
  int pending;
  int cycles        = 0;
  int send_idle_pct = 18;
  int recv_idle_pct = 70;

  zero_tracking_modular_product dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  ztmp_product_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .failures   (failures),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("zero_tracking_modular_product_tb NOT OK");
      $finish;
    end
  end

  // offer one item, with random idle cycles ahead of it; valid stays high after
  task automatic send_factor(input logic [1:0] kind, input logic [63:0] operand);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= operand;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the input until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one APB transfer; select is left high for a following transfer
  task automatic access_reg(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  // operand mix: zeros, multiples of the modulus, small, extreme and raw values
  function automatic logic [63:0] make_operand(input logic [63:0] field);
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = field * 64'($urandom_range(1000));
      2, 3: v = {$urandom, $urandom} % field;
      4: begin
        case ($urandom_range(3))
          0: v = OP_MAX;
          1: v = OP_MIN;
          2: v = 64'd1;
          default: v = field - 64'd1;
        endcase
      end
      default: v = {$urandom, $urandom};
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  // set a modulus while idle, read it back, then stream random items
  task automatic run_phase(input logic [31:0] mod_word, input int n_items,
                           input int send_pct, input int recv_pct);
    logic [63:0] field;
    logic [1:0]  kind;
    int          pick;
    drain_results();
    access_reg(1'b1, CFG_ADDR_MODULUS, mod_word);
    access_reg(1'b0, CFG_ADDR_MODULUS, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    field = (mod_word[MOD_BITS-1:0] < 2) ? 64'd2 : 64'(mod_word[MOD_BITS-1:0]);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 42)      kind = REQ_MUL;
      else if (pick < 82) kind = REQ_DIV;
      else if (pick < 94) kind = REQ_LOAD;
      else                kind = REQ_UNUSED;
      send_factor(kind, make_operand(field));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at the reset modulus
    send_factor(REQ_LOAD, 64'd5);
    send_factor(REQ_MUL, OP_MAX);
    send_factor(REQ_MUL, OP_MIN);
    send_factor(REQ_DIV, 64'd3);
    send_factor(REQ_DIV, 64'hFFFF_FFFF_FFFF_FFFF);
    send_factor(REQ_MUL, 64'd0);
    send_factor(REQ_MUL, P0);
    send_factor(REQ_MUL, -P0);
    send_factor(REQ_DIV, 64'd0);
    send_factor(REQ_DIV, P0 * 2);
    send_factor(REQ_DIV, -(P0 * 3));
    send_factor(REQ_DIV, 64'd0);
    drain_results();
    send_factor(REQ_UNUSED, 64'd0);
    send_factor(REQ_UNUSED, 64'h1234_5678_9ABC_DEF0);
    send_factor(REQ_LOAD, 64'd0);
    send_factor(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_factor(REQ_LOAD, P0 - 1);
    send_factor(REQ_MUL, P0 + 1);
    send_factor(REQ_DIV, P0 - 1);
    send_factor(REQ_LOAD, OP_MIN);
    send_factor(REQ_DIV, OP_MAX);
    send_factor(REQ_MUL, 64'd1);
    send_factor(REQ_LOAD, 64'd1);
    send_factor(REQ_DIV, 64'd1);

    // sender idles lightly, receiver heavily
    run_phase(32'd7, 400, 18, 70);
    run_phase(32'd0, 80, 18, 70);
    run_phase(32'd1, 60, 18, 70);
    // sender idles heavily, receiver lightly
    run_phase(32'hFFFF_FFFF, 80, 70, 18);
    run_phase(32'd65521, 350, 70, 18);
    run_phase(32'd15, 150, 70, 18);
    // no idling on either side
    run_phase(32'(MOD_RESET), 100, 0, 0);
    run_phase(32'h8000_0003, 250, 0, 0);
    run_phase(32'd2, 60, 0, 0);
    run_phase(32'd1073741825, 50, 0, 0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("zero_tracking_modular_product_tb OK");
    end else begin
      $display("zero_tracking_modular_product_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ztmp_pkg.sv
src/ztmp_dpath.sv
src/ztmp_ctrl.sv
src/zero_tracking_modular_product.sv
src/ztmp_check.sv
dv/ztmp_product_checker.sv
dv/zero_tracking_modular_product_tb.sv
